// ----- design/assert_macros.svh -----
// Assertion helpers for the checker file wsct_checker.sv.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define WSCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wsct assertion failed");

// Same-cycle implication.
`define WSCT_ASSERT_IMPL(lbl, ante, cons) `WSCT_ASSERT(lbl, (ante) |-> (cons))

`endif

// ----- design/wsct_pkg.sv -----
// ----------------------------------------------------------------------------
// wsct_pkg
// Types, widths and register codes of the signal cycle timer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsct_pkg;

  localparam int unsigned Roads       = 4;
  localparam int unsigned FracBitsDef = 20;

  localparam int unsigned ArrBits     = 16;
  localparam int unsigned SatBits     = 12;
  localparam int unsigned LostBits    = 8;
  localparam int unsigned HdwBits     = 8;
  localparam int unsigned RunBits     = 16;
  localparam int unsigned GreenBits   = 10;
  localparam int unsigned CapBits     = 16;
  localparam int unsigned CycBits     = 20;
  localparam int unsigned CntBits     = 16;
  localparam int unsigned AccBits     = 32;
  localparam int unsigned CapSumBits  = CapBits + $clog2(Roads);
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [LostBits-1:0]  LostRst    = 8'd12;
  localparam logic [HdwBits-1:0]   HeadwayRst = 8'd25;
  localparam logic [RunBits-1:0]   RunningRst = 16'd3600;
  localparam logic [GreenBits-1:0] GreenRst   = 10'd120;
  localparam logic [Roads-1:0][SatBits-1:0] SatRst = {12'd1700, 12'd1500, 12'd800, 12'd1800};

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LOST    = 3'd0,
    CFG_HEADWAY = 3'd1,
    CFG_RUNNING = 3'd2,
    CFG_GREEN   = 3'd3,
    CFG_SAT0    = 3'd4,
    CFG_SAT1    = 3'd5,
    CFG_SAT2    = 3'd6,
    CFG_SAT3    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic ratio_step;
    logic mul;
    logic div_load;
    logic div_step;
  } lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } merge_ctrl_t;

endpackage

`default_nettype wire

// ----- design/wsct_if.sv -----
// ----------------------------------------------------------------------------
// wsct_if
// Valid/ready channels for signal cycle words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsct_in_if;
  logic        valid;
  logic        ready;
  logic        start_run;
  logic        mode;
  logic [15:0] arrivals_0;
  logic [15:0] arrivals_1;
  logic [15:0] arrivals_2;
  logic [15:0] arrivals_3;

  modport source (output valid, start_run, mode, arrivals_0, arrivals_1, arrivals_2,
                  arrivals_3, input ready);
  modport sink (input valid, start_run, mode, arrivals_0, arrivals_1, arrivals_2,
                arrivals_3, output ready);
endinterface

interface wsct_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cycle_number;
  logic [19:0] cycle_time;
  logic [19:0] green_total;
  logic [15:0] capacity_0;
  logic [15:0] capacity_1;
  logic [15:0] capacity_2;
  logic [15:0] capacity_3;
  logic [31:0] capacity_sum;
  logic        run_done;

  modport source (output valid, cycle_number, cycle_time, green_total, capacity_0,
                  capacity_1, capacity_2, capacity_3, capacity_sum, run_done, input ready);
  modport sink (input valid, cycle_number, cycle_time, green_total, capacity_0,
                capacity_1, capacity_2, capacity_3, capacity_sum, run_done, output ready);
endinterface

`default_nettype wire

// ----- design/webster_signal_cycle_timer_unit.sv -----
// Flow: a word is taken in idle; the lanes step their bit-serial flow ratios, then
// multiply while the shared cycle-time divider loads, then the lanes load their
// capacity dividers, then both dividers step, then the accumulate, which holds
// while the output stalls. A new word is taken only after the last is accumulated.
// Reset: asynchronous, active low, no clearing pass; configuration registers take
// their documented defaults, control registers and run totals clear to zero.
// ----------------------------------------------------------------------------
// webster_signal_cycle_timer_unit
// Webster or static cycle time (per mode), per-road capacity, run totals.
// ----------------------------------------------------------------------------
`default_nettype none

module webster_signal_cycle_timer_unit #(
  parameter int unsigned FRAC_BITS = wsct_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wsct_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [wsct_pkg::CfgDataBits-1:0] cfg_data_i,
  wsct_in_if.sink                          in_i,
  wsct_out_if.source                       out_o
);
  import wsct_pkg::*;

  localparam int unsigned CntW = $clog2(FRAC_BITS + 11);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RATIO, ST_MUL, ST_LOAD, ST_DIV, ST_ACC
  } state_e;

  state_e state_q;
  logic [CntW-1:0] cnt_q;

  logic [LostBits-1:0]            lost_q;
  logic [HdwBits-1:0]             headway_q;
  logic [RunBits-1:0]             running_q;
  logic [GreenBits-1:0]           green_q;
  logic [Roads-1:0][SatBits-1:0]  sat_q;

  logic start_q, mode_q;
  logic [CntBits-1:0] cycles_q;
  logic [AccBits-1:0] elapsed_q, capacc_q;

  logic out_valid_q, run_done_q;
  logic [CntBits-1:0] cyc_num_q;
  logic [CycBits-1:0] cyc_time_q, green_tot_q;
  logic [Roads-1:0][CapBits-1:0] cap_q;
  logic [AccBits-1:0] capsum_q;

  logic accept;
  lane_ctrl_t  lane_ctrl;
  merge_ctrl_t merge_ctrl;
  logic [Roads-1:0][ArrBits-1:0]   arrivals;
  logic [Roads-1:0][FRAC_BITS-1:0] ratios;
  logic [Roads-1:0][CapBits-1:0]   caps;
  logic [FRAC_BITS:0]              ysum;
  logic [CycBits-1:0]              cyc_time;
  logic [CapSumBits-1:0]           capsum;

  logic [CntBits-1:0] base_cyc, next_cyc;
  logic [AccBits-1:0] base_el, base_cap;
  logic [AccBits:0]   el_sum, cap_sum;
  logic [AccBits-1:0] next_el, next_cap;
  logic [CycBits-1:0] green_tot;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_q    <= LostRst;
      headway_q <= HeadwayRst;
      running_q <= RunningRst;
      green_q   <= GreenRst;
      sat_q     <= SatRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOST:    lost_q    <= cfg_data_i[LostBits-1:0];
        CFG_HEADWAY: headway_q <= cfg_data_i[HdwBits-1:0];
        CFG_RUNNING: running_q <= cfg_data_i[RunBits-1:0];
        CFG_GREEN:   green_q   <= cfg_data_i[GreenBits-1:0];
        CFG_SAT0:    sat_q[0]  <= cfg_data_i[SatBits-1:0];
        CFG_SAT1:    sat_q[1]  <= cfg_data_i[SatBits-1:0];
        CFG_SAT2:    sat_q[2]  <= cfg_data_i[SatBits-1:0];
        CFG_SAT3:    sat_q[3]  <= cfg_data_i[SatBits-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign arrivals[0] = in_i.arrivals_0;
  assign arrivals[1] = in_i.arrivals_1;
  assign arrivals[2] = in_i.arrivals_2;
  assign arrivals[3] = in_i.arrivals_3;

  always_comb begin
    lane_ctrl.load       = accept;
    lane_ctrl.ratio_step = (state_q == ST_RATIO);
    lane_ctrl.mul        = (state_q == ST_MUL);
    lane_ctrl.div_load   = (state_q == ST_LOAD);
    lane_ctrl.div_step   = (state_q == ST_DIV) && (cnt_q < CntW'(CapBits));
    merge_ctrl.load      = (state_q == ST_MUL);
    merge_ctrl.step      = (state_q == ST_DIV);
  end

  for (genvar g = 0; g < Roads; g++) begin : gen_lane
    wsct_lane #(.FracBits(FRAC_BITS)) u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (lane_ctrl),
      .arrivals_i (arrivals[g]),
      .sat_flow_i (sat_q[g]),
      .headway_i  (headway_q),
      .ysum_i     (ysum),
      .ratio_o    (ratios[g]),
      .capacity_o (caps[g])
    );
  end

  wsct_merge #(.FracBits(FRAC_BITS)) u_merge (
    .clk_i        (clk_i),
    .ctrl_i       (merge_ctrl),
    .mode_i       (mode_q),
    .lost_i       (lost_q),
    .green_i      (green_q),
    .ratios_i     (ratios),
    .caps_i       (caps),
    .ysum_o       (ysum),
    .cycle_time_o (cyc_time),
    .capsum_o     (capsum)
  );

  // run totals, cleared ahead of a word that starts a run
  always_comb begin
    base_cyc = start_q ? '0 : cycles_q;
    base_el  = start_q ? '0 : elapsed_q;
    base_cap = start_q ? '0 : capacc_q;
    next_cyc = (base_cyc == '1) ? base_cyc : base_cyc + CntBits'(1);
    el_sum   = {1'b0, base_el} + (AccBits + 1)'(cyc_time);
    cap_sum  = {1'b0, base_cap} + (AccBits + 1)'(capsum);
    next_el  = el_sum[AccBits] ? '1 : el_sum[AccBits-1:0];
    next_cap = cap_sum[AccBits] ? '1 : cap_sum[AccBits-1:0];
    green_tot = (cyc_time >= CycBits'(lost_q)) ? cyc_time - CycBits'(lost_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      start_q     <= 1'b0;
      mode_q      <= 1'b0;
      cycles_q    <= '0;
      elapsed_q   <= '0;
      capacc_q    <= '0;
      out_valid_q <= 1'b0;
      run_done_q  <= 1'b0;
      cyc_num_q   <= '0;
      cyc_time_q  <= '0;
      green_tot_q <= '0;
      cap_q       <= '0;
      capsum_q    <= '0;
    end else begin
      // drop the taken word unless the next one replaces it right away
      if (out_valid_q && out_o.ready && (state_q != ST_ACC)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            start_q <= in_i.start_run;
            mode_q  <= in_i.mode;
            cnt_q   <= '0;
            state_q <= ST_RATIO;
          end
        end
        ST_RATIO: begin
          if (cnt_q == CntW'(FRAC_BITS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        ST_MUL:  state_q <= ST_LOAD;
        ST_LOAD: state_q <= ST_DIV;
        ST_DIV: begin
          if (cnt_q == CntW'(FRAC_BITS + 9)) begin
            cnt_q   <= '0;
            state_q <= ST_ACC;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        ST_ACC: begin
          // hold until the output register frees up
          if (!out_valid_q || out_o.ready) begin
            cycles_q    <= next_cyc;
            elapsed_q   <= next_el;
            capacc_q    <= next_cap;
            out_valid_q <= 1'b1;
            cyc_num_q   <= next_cyc;
            cyc_time_q  <= cyc_time;
            green_tot_q <= green_tot;
            cap_q       <= caps;
            capsum_q    <= next_cap;
            run_done_q  <= next_el > AccBits'(running_q);
            state_q     <= ST_IDLE;
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.cycle_number = cyc_num_q;
  assign out_o.cycle_time   = cyc_time_q;
  assign out_o.green_total  = green_tot_q;
  assign out_o.capacity_0   = cap_q[0];
  assign out_o.capacity_1   = cap_q[1];
  assign out_o.capacity_2   = cap_q[2];
  assign out_o.capacity_3   = cap_q[3];
  assign out_o.capacity_sum = capsum_q;
  assign out_o.run_done     = run_done_q;

endmodule

`default_nettype wire

// ----- design/wsct_lane.sv -----
// ----------------------------------------------------------------------------
// wsct_lane
// One road: clamp, bit-serial flow ratio, scaled product, capacity divider.
// ----------------------------------------------------------------------------
`default_nettype none

module wsct_lane #(
  parameter int unsigned FracBits = wsct_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  wsct_pkg::lane_ctrl_t          ctrl_i,
  input  logic [wsct_pkg::ArrBits-1:0]  arrivals_i,
  input  logic [wsct_pkg::SatBits-1:0]  sat_flow_i,
  input  logic [wsct_pkg::HdwBits-1:0]  headway_i,
  input  logic [FracBits:0]             ysum_i,
  output logic [FracBits-1:0]           ratio_o,
  output logic [wsct_pkg::CapBits-1:0]  capacity_o
);
  import wsct_pkg::*;

  localparam int unsigned ProdBits = FracBits + SatBits;
  localparam int unsigned NumBits  = ProdBits + 4;
  localparam int unsigned DenBits  = FracBits + 1 + HdwBits;
  localparam int unsigned HiBits   = NumBits - CapBits;

  logic [SatBits-1:0]  lim;
  logic [SatBits-1:0]  clamped;
  logic [SatBits:0]    rt;
  logic                rbit;
  logic [SatBits-1:0]  rem_q, rem_d;
  logic [FracBits-1:0] ratio_q;
  logic [ProdBits-1:0] prod_q;
  logic [DenBits-1:0]  den_q;
  logic [NumBits-1:0]  num;
  logic [DenBits:0]    ct;
  logic                cbit;
  logic [DenBits-1:0]  crem_q, crem_d;
  logic [CapBits-1:0]  cq_q;

  always_comb begin
    lim = SatBits'(sat_flow_i / Roads);
    if (lim == '0) begin
      clamped = '0;
    end else if (arrivals_i > ArrBits'(lim)) begin
      clamped = lim - SatBits'(1);
    end else begin
      clamped = SatBits'(arrivals_i);
    end
  end

  // restoring step of v * 2^F / s, one quotient bit a cycle
  assign rt    = {rem_q, 1'b0};
  assign rbit  = (sat_flow_i != '0) && (rt >= {1'b0, sat_flow_i});
  assign rem_d = rbit ? SatBits'(rt - {1'b0, sat_flow_i}) : SatBits'(rt);

  // times ten as two shifted adds
  assign num = NumBits'({prod_q, 3'b000}) + NumBits'({prod_q, 1'b0});

  assign ct     = {crem_q, cq_q[CapBits-1]};
  assign cbit   = ct >= {1'b0, den_q};
  assign crem_d = cbit ? DenBits'(ct - {1'b0, den_q}) : DenBits'(ct);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q   <= clamped;
      ratio_q <= '0;
    end else if (ctrl_i.ratio_step) begin
      rem_q   <= rem_d;
      ratio_q <= {ratio_q[FracBits-2:0], rbit};
    end
    if (ctrl_i.mul) begin
      prod_q <= ProdBits'(ratio_q) * ProdBits'(sat_flow_i);
      den_q  <= DenBits'(ysum_i) * DenBits'(headway_i);
    end
    if (ctrl_i.div_load) begin
      crem_q <= DenBits'(num[NumBits-1 -: HiBits]);
      cq_q   <= num[CapBits-1:0];
    end else if (ctrl_i.div_step) begin
      crem_q <= crem_d;
      cq_q   <= {cq_q[CapBits-2:0], cbit};
    end
  end

  assign ratio_o = ratio_q;

  always_comb begin
    if (den_q == '0) begin
      capacity_o = '0;
    end else if (cq_q == '1) begin
      capacity_o = cq_q;
    end else begin
      capacity_o = cq_q + CapBits'(crem_q != '0);
    end
  end

endmodule

`default_nettype wire

// ----- design/wsct_merge.sv -----
// ----------------------------------------------------------------------------
// wsct_merge
// Sums the lanes' ratios and capacities and forms the cycle time.
// ----------------------------------------------------------------------------
`default_nettype none

module wsct_merge #(
  parameter int unsigned FracBits = wsct_pkg::FracBitsDef
) (
  input  logic                                            clk_i,
  input  wsct_pkg::merge_ctrl_t                           ctrl_i,
  input  logic                                            mode_i,
  input  logic [wsct_pkg::LostBits-1:0]                   lost_i,
  input  logic [wsct_pkg::GreenBits-1:0]                  green_i,
  input  logic [wsct_pkg::Roads-1:0][FracBits-1:0]        ratios_i,
  input  logic [wsct_pkg::Roads-1:0][wsct_pkg::CapBits-1:0] caps_i,
  output logic [FracBits:0]                               ysum_o,
  output logic [wsct_pkg::CycBits-1:0]                    cycle_time_o,
  output logic [wsct_pkg::CapSumBits-1:0]                 capsum_o
);
  import wsct_pkg::*;

  localparam int unsigned SumBits = FracBits + $clog2(Roads);
  localparam int unsigned NumHi   = 10;
  localparam int unsigned NB      = FracBits + NumHi;
  localparam int unsigned DB      = FracBits + 2;
  localparam logic [CycBits-1:0] CycMax = '1;

  logic [SumBits-1:0]   ysum;
  logic [NumHi-1:0]     num_hi;
  logic [FracBits:0]    slack;
  logic [NB-1:0]        nsh_q;
  logic [DB-1:0]        den_q, rem_q, rem_d;
  logic [DB:0]          t;
  logic                 qbit;
  logic [GreenBits:0]   gl;
  logic [CycBits-1:0]   stat_cyc, dyn_cyc;

  always_comb begin
    ysum     = '0;
    capsum_o = '0;
    for (int i = 0; i < Roads; i++) begin
      ysum     = ysum + SumBits'(ratios_i[i]);
      capsum_o = capsum_o + CapSumBits'(caps_i[i]);
    end
  end

  // ratio sum reaches one at most, when every road sits exactly at its limit
  assign ysum_o = (FracBits + 1)'(ysum);

  assign num_hi = NumHi'(lost_i) + NumHi'({lost_i, 1'b0}) + NumHi'(10);
  assign slack  = {1'b1, {FracBits{1'b0}}} - ysum_o;

  assign t     = {rem_q, nsh_q[NB-1]};
  assign qbit  = t >= {1'b0, den_q};
  assign rem_d = qbit ? DB'(t - {1'b0, den_q}) : DB'(t);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      nsh_q <= {num_hi, {FracBits{1'b0}}};
      den_q <= {slack, 1'b0};
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      nsh_q <= {nsh_q[NB-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign gl       = {1'b0, green_i} + (GreenBits + 1)'(lost_i);
  assign stat_cyc = CycBits'(gl * Roads);

  always_comb begin
    if (nsh_q >= NB'(CycMax)) begin
      dyn_cyc = CycMax;
    end else begin
      dyn_cyc = CycBits'(nsh_q) + CycBits'(rem_q != '0);
    end
  end

  assign cycle_time_o = mode_i ? stat_cyc : dyn_cyc;

endmodule

`default_nettype wire

// ----- design/wsct_checker.sv -----
// ----------------------------------------------------------------------------
// wsct_checker
// Port-level checks on the signal cycle timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wsct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] cycle_number_i,
  input logic [19:0] cycle_time_i,
  input logic [19:0] green_total_i
);

  // a stalled result word stays offered
  `WSCT_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> out_valid_i)
  // one word at a time: busy right after taking a word
  `WSCT_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_i) |=> !in_ready_i)
  `WSCT_ASSERT_IMPL(a_green_le_cycle, out_valid_i, green_total_i <= cycle_time_i)
  `WSCT_ASSERT_IMPL(a_count_nonzero, out_valid_i, cycle_number_i != 16'd0)

endmodule

bind webster_signal_cycle_timer_unit wsct_checker u_wsct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .cycle_number_i (out_o.cycle_number),
  .cycle_time_i   (out_o.cycle_time),
  .green_total_i  (out_o.green_total)
);

`default_nettype wire
